// ===== rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    localparam int unsigned POS_W   = 17;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CFG_W   = 17;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HEADER_VALUE_RST    = 8'd165;
    localparam logic [BYTE_W-1:0] USER_VALUE_RST      = 8'd1;
    localparam logic [CFG_W-1:0]  MAX_FRAME_BYTES_RST = 17'd1024;

    // byte positions within a frame, counted from 1
    localparam logic [POS_W-1:0] POS_HEADER = 17'd1;
    localparam logic [POS_W-1:0] POS_USER   = 17'd2;
    localparam logic [POS_W-1:0] POS_TYPE   = 17'd3;
    localparam logic [POS_W-1:0] POS_LEN_LO = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI = 17'd5;
    localparam logic [POS_W-1:0] POS_ID_LO  = 17'd6;
    localparam logic [POS_W-1:0] POS_ID_HI  = 17'd7;

    // header bytes plus checksum byte
    localparam logic [POS_W-1:0] FRAME_OVERHEAD = 17'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_VALUE    = 2'd0,
        CFG_USER_VALUE      = 2'd1,
        CFG_MAX_FRAME_BYTES = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_MISMATCH = 2'd2,
        KIND_TOO_LONG = 2'd3
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_value;
        logic [BYTE_W-1:0] user_value;
        logic [CFG_W-1:0]  max_frame_bytes;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] msg_type;
        logic [LEN_W-1:0]  msg_id;
        logic [LEN_W-1:0]  payload_len;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sfd_parser.sv =====
`default_nettype none

module sfd_parser
    import sfd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [LEN_W-1:0]  length_hold_reg, length_hold_next;
    logic [POS_W-1:0]  frame_total_reg, frame_total_next;
    logic [BYTE_W-1:0] type_hold_reg, type_hold_next;
    logic [LEN_W-1:0]  ident_hold_reg, ident_hold_next;

    logic              fire;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum_plus;
    logic              clear;
    logic              emit;
    kind_t             kind;

    assign fire     = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign b         = in_byte_reg;
    assign pos       = byte_position_reg + POS_W'(1);
    assign sum_plus  = running_sum_reg + b;

    always_comb
    begin
        length_hold_next = length_hold_reg;
        type_hold_next   = type_hold_reg;
        ident_hold_next  = ident_hold_reg;
        frame_total_next = frame_total_reg;
        clear            = 1'b0;
        emit             = 1'b0;
        kind             = KIND_PAYLOAD;
        case (pos)
            POS_HEADER:
            begin
                clear = (b != cfg.header_value);
            end
            POS_USER:
            begin
                clear = (b != cfg.user_value);
            end
            POS_TYPE:
            begin
                type_hold_next = b;
            end
            POS_LEN_LO:
            begin
                length_hold_next = {8'd0, b};
            end
            POS_LEN_HI:
            begin
                length_hold_next = {b, length_hold_reg[7:0]};
            end
            POS_ID_LO:
            begin
                ident_hold_next = {8'd0, b};
            end
            POS_ID_HI:
            begin
                ident_hold_next  = {b, ident_hold_reg[7:0]};
                frame_total_next = POS_W'(length_hold_reg) + FRAME_OVERHEAD;
                if (frame_total_next > cfg.max_frame_bytes)
                begin
                    clear = 1'b1;
                    emit  = 1'b1;
                    kind  = KIND_TOO_LONG;
                end
            end
            default:
            begin
                emit = 1'b1;
                if (pos == frame_total_reg)
                begin
                    // checksum byte: frame sum including it must wrap to zero
                    clear = 1'b1;
                    kind  = (sum_plus == '0) ? KIND_GOOD : KIND_MISMATCH;
                end
            end
        endcase
    end

    always_comb
    begin
        byte_position_next = pos;
        running_sum_next   = sum_plus;
        if (clear)
        begin
            byte_position_next = '0;
            running_sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            running_sum_reg   <= '0;
            length_hold_reg   <= '0;
            frame_total_reg   <= '0;
            type_hold_reg     <= '0;
            ident_hold_reg    <= '0;
        end
        else if (fire)
        begin
            byte_position_reg <= byte_position_next;
            running_sum_reg   <= running_sum_next;
            length_hold_reg   <= clear ? '0 : length_hold_next;
            frame_total_reg   <= clear ? '0 : frame_total_next;
            type_hold_reg     <= clear ? '0 : type_hold_next;
            ident_hold_reg    <= clear ? '0 : ident_hold_next;
        end
    end

    assign res_valid        = fire && emit;
    assign res.kind         = kind;
    assign res.payload_byte = (kind == KIND_PAYLOAD) ? b : '0;
    assign res.msg_type     = type_hold_next;
    assign res.msg_id       = ident_hold_next;
    assign res.payload_len  = length_hold_next;

endmodule

`default_nettype wire

// ===== rtl/sfd_out_reg.sv =====
`default_nettype none

module sfd_out_reg
    import sfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    output logic         res_ready,
    input  wire result_t res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    out_valid_reg;
    result_t out_res_reg;

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

// ===== rtl/serial_frame_deframer_core.sv =====
`default_nettype none

// Length-prefixed serial frame deframer. Takes one received byte per
// transaction and parses header, user id, type, 16-bit little-endian length,
// 16-bit little-endian id, payload and a two's-complement checksum byte.
// Each payload byte comes out as a kind-0 transaction as it arrives; the
// checksum byte gives one good or mismatch transaction, and a frame whose
// length plus 8 exceeds max_frame_bytes gives a length-error transaction on
// its seventh byte. Header and user-id bytes that do not match restart the
// search with no output. One byte is taken per clock while out_ready is high;
// each passes the input register, then the result register. Configuration
// writes take effect on the next clock and should be made while the block is
// idle.
module serial_frame_deframer_core
    import sfd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [1:0]                kind,
    output logic [BYTE_W-1:0]         payload_byte,
    output logic [BYTE_W-1:0]         msg_type,
    output logic [LEN_W-1:0]          msg_id,
    output logic [LEN_W-1:0]          payload_len
);

    cfg_t    cfg_reg;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value    <= HEADER_VALUE_RST;
            cfg_reg.user_value      <= USER_VALUE_RST;
            cfg_reg.max_frame_bytes <= MAX_FRAME_BYTES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_VALUE:    cfg_reg.header_value    <= cfg_data[BYTE_W-1:0];
                CFG_USER_VALUE:      cfg_reg.user_value      <= cfg_data[BYTE_W-1:0];
                CFG_MAX_FRAME_BYTES: cfg_reg.max_frame_bytes <= cfg_data;
                default:             ;
            endcase
        end
    end

    sfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    sfd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign payload_byte = out_res.payload_byte;
    assign msg_type     = out_res.msg_type;
    assign msg_id       = out_res.msg_id;
    assign payload_len  = out_res.payload_len;

endmodule

`default_nettype wire
